[rtl/core/lcdc_pkg.sv]
// Shared types, register offsets and small decode functions of the LCD controller register file.
// Used by lcdc_pal, lcdc_regs and the top level; depends on nothing else.
package lcdc_pkg;

	localparam int OFFSET_W = 12;
	localparam int WORD_W   = 32;
	localparam int SIZE_W   = 11;
	localparam int EVENT_W  = 5;
	localparam int PAL_IDX_W = 7;

	localparam logic [OFFSET_W-1:0] OFF_TIMING0  = 12'h000;
	localparam logic [OFFSET_W-1:0] OFF_TIMING1  = 12'h004;
	localparam logic [OFFSET_W-1:0] OFF_TIMING2  = 12'h008;
	localparam logic [OFFSET_W-1:0] OFF_TIMING3  = 12'h00C;
	localparam logic [OFFSET_W-1:0] OFF_UPBASE   = 12'h010;
	localparam logic [OFFSET_W-1:0] OFF_LPBASE   = 12'h014;
	localparam logic [OFFSET_W-1:0] OFF_CONTROL  = 12'h018;
	localparam logic [OFFSET_W-1:0] OFF_IMSC     = 12'h01C;
	localparam logic [OFFSET_W-1:0] OFF_RIS      = 12'h020;
	localparam logic [OFFSET_W-1:0] OFF_MIS      = 12'h024;
	localparam logic [OFFSET_W-1:0] OFF_ICR      = 12'h028;
	localparam logic [OFFSET_W-1:0] OFF_UPCURR   = 12'h02C;
	localparam logic [OFFSET_W-1:0] OFF_LPCURR   = 12'h030;
	localparam logic [OFFSET_W-1:0] OFF_ID_START = 12'hFE0;

	localparam logic [SIZE_W-1:0] PPL_RESET   = 11'd16;
	localparam logic [SIZE_W-1:0] LINES_RESET = 11'd1;

	typedef enum logic [1:0] {
		FAULT_OK      = 2'd0,
		FAULT_UNKNOWN = 2'd1,
		FAULT_DIR     = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_8BIT  = 2'd1,
		MODE_16BIT = 2'd2
	} pix_mode_t;

	// Palette access issued by the register decode.
	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [PAL_IDX_W-1:0] idx;
		logic [WORD_W-1:0]    wdata;
	} pal_cmd_t;

	// Outcome of one access, with the screen state as it stands after it.
	typedef struct packed {
		logic [WORD_W-1:0] rdata;
		logic              pal_rd;
		fault_t            fault;
		logic              irq;
		logic              screen_on;
		logic [SIZE_W-1:0] ppl;
		logic [SIZE_W-1:0] lines;
		pix_mode_t         mode;
		logic [WORD_W-1:0] frame_base;
	} acc_res_t;

	function automatic pix_mode_t decode_mode(input logic [WORD_W-1:0] ctl);
		pix_mode_t m;
		case (ctl[3:1])
			3'd3:    m = MODE_8BIT;
			3'd4:    m = MODE_16BIT;
			3'd6:    m = MODE_16BIT;
			default: m = MODE_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] id_byte(input logic [2:0] sel);
		logic [7:0] b;
		case (sel)
			3'd0:    b = 8'h11;
			3'd1:    b = 8'h11;
			3'd2:    b = 8'h24;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h0D;
			3'd5:    b = 8'hF0;
			3'd6:    b = 8'h05;
			default: b = 8'hB1;
		endcase
		return b;
	endfunction

endpackage

[rtl/core/lcdc_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
module lcdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/core/lcdc_pal.sv]
// Palette store: a RAM plus one valid bit per word so that unwritten words read as zero.
// Depends on lcdc_pkg and lcdc_ram.
module lcdc_pal #(
	parameter int DEPTH = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lcdc_pkg::pal_cmd_t      cmd,
	output logic [lcdc_pkg::WORD_W-1:0] rdata
);
	import lcdc_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DEPTH-1:0]  vld_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  idx;
	logic [WORD_W-1:0] ram_rdata;

	assign idx = cmd.idx[IDX_W-1:0];

	lcdc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(idx),
		.wdata(cmd.wdata),
		.re   (cmd.re),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.we) begin
				vld_q[idx] <= 1'b1;
			end
			if (cmd.re) begin
				rd_vld_q <= vld_q[idx];
			end
		end
	end

	assign rdata = rd_vld_q ? ram_rdata : '0;
endmodule

[rtl/core/lcdc_regs.sv]
// Control register bank and address decode: applies one access to the registers and
// issues the palette command. Depends on lcdc_pkg.
module lcdc_regs #(
	parameter int PALETTE_DEPTH = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         kind,
	input  logic [15:0]                  offset,
	input  logic [lcdc_pkg::WORD_W-1:0]  write_data,
	input  logic [lcdc_pkg::EVENT_W-1:0] irq_events,
	output lcdc_pkg::acc_res_t           res,
	output lcdc_pkg::pal_cmd_t           pal_cmd
);
	import lcdc_pkg::*;

	logic [WORD_W-1:0] timing_q [4];
	logic [WORD_W-1:0] upbase_q, lpbase_q, control_q, mask_q, raw_q;
	logic              en_q;
	logic [SIZE_W-1:0] ppl_pend_q, lines_pend_q, ppl_lat_q, lines_lat_q;
	pix_mode_t         mode_q;

	logic [OFFSET_W-1:0] off;
	logic [WORD_W-1:0]   raw_ev, raw_n, upbase_n, lpbase_n, control_n, mask_n, rd;
	logic                en_n, pal_hit, pal_ok, id_hit, latch, wr_t0, wr_t1, wr_t2, wr_t3;
	logic [SIZE_W-1:0]   ppl_pend_n, lines_pend_n, ppl_lat_n, lines_lat_n;
	logic [6:0]          ppl_blocks;
	pix_mode_t           mode_n;
	fault_t              fault;

	assign off     = offset[OFFSET_W-1:0];
	assign raw_ev  = raw_q | {{(WORD_W-EVENT_W){1'b0}}, irq_events};
	assign pal_hit = (off[11:9] == 3'b001);
	assign pal_ok  = ({1'b0, off[8:2]} < 8'(PALETTE_DEPTH));
	assign id_hit  = (off >= OFF_ID_START) && (off[1:0] == 2'b00);
	assign ppl_blocks = {1'b0, write_data[7:2]} + 7'd1;

	always_comb begin
		rd = '0;
		fault = FAULT_OK;
		raw_n = raw_ev;
		upbase_n = upbase_q;
		lpbase_n = lpbase_q;
		control_n = control_q;
		mask_n = mask_q;
		en_n = en_q;
		ppl_pend_n = ppl_pend_q;
		lines_pend_n = lines_pend_q;
		ppl_lat_n = ppl_lat_q;
		lines_lat_n = lines_lat_q;
		mode_n = mode_q;
		latch = 1'b0;
		wr_t0 = 1'b0;
		wr_t1 = 1'b0;
		wr_t2 = 1'b0;
		wr_t3 = 1'b0;
		pal_cmd.we = 1'b0;
		pal_cmd.re = 1'b0;
		pal_cmd.idx = off[8:2];
		pal_cmd.wdata = write_data;

		if (pal_hit) begin
			if (!pal_ok) begin
				fault = FAULT_UNKNOWN;
			end else if (kind) begin
				pal_cmd.we = acc;
			end else begin
				pal_cmd.re = acc;
			end
		end else if (!kind) begin
			if (id_hit) begin
				rd = {24'd0, id_byte(off[4:2])};
			end else begin
				case (off)
					OFF_TIMING0, OFF_TIMING1, OFF_TIMING2, OFF_TIMING3:
						rd = timing_q[off[3:2]];
					OFF_UPBASE, OFF_UPCURR: rd = upbase_q;
					OFF_LPBASE, OFF_LPCURR: rd = lpbase_q;
					OFF_CONTROL: rd = control_q;
					OFF_IMSC:    rd = mask_q;
					OFF_RIS:     rd = raw_ev;
					OFF_MIS:     rd = raw_ev & mask_q;
					OFF_ICR:     fault = FAULT_DIR;
					default:     fault = FAULT_UNKNOWN;
				endcase
			end
		end else begin
			case (off)
				OFF_TIMING0: begin
					wr_t0 = 1'b1;
					ppl_pend_n = {ppl_blocks, 4'b0000};
					latch = en_q;
				end
				OFF_TIMING1: begin
					wr_t1 = 1'b1;
					lines_pend_n = {1'b0, write_data[9:0]} + 11'd1;
					latch = en_q;
				end
				OFF_TIMING2: wr_t2 = 1'b1;
				OFF_TIMING3: wr_t3 = 1'b1;
				OFF_UPBASE:  upbase_n = write_data;
				OFF_LPBASE:  lpbase_n = write_data;
				OFF_CONTROL: begin
					control_n = write_data;
					if (write_data[0] && write_data[11] && !en_q) begin
						en_n = 1'b1;
						latch = 1'b1;
					end
				end
				OFF_IMSC: mask_n = write_data;
				OFF_ICR:  raw_n = raw_ev & ~write_data;
				OFF_RIS, OFF_MIS, OFF_UPCURR, OFF_LPCURR: fault = FAULT_DIR;
				default: fault = FAULT_UNKNOWN;
			endcase
		end

		if (latch) begin
			ppl_lat_n = ppl_pend_n;
			lines_lat_n = lines_pend_n;
			mode_n = decode_mode(control_n);
		end

		res.rdata = rd;
		res.pal_rd = pal_cmd.re;
		res.fault = fault;
		res.irq = |(raw_n & mask_n);
		res.screen_on = en_n;
		res.ppl = ppl_lat_n;
		res.lines = lines_lat_n;
		res.mode = mode_n;
		res.frame_base = upbase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				timing_q[i] <= '0;
			end
			upbase_q <= '0;
			lpbase_q <= '0;
			control_q <= '0;
			mask_q <= '0;
			raw_q <= '0;
			en_q <= 1'b0;
			ppl_pend_q <= PPL_RESET;
			lines_pend_q <= LINES_RESET;
			ppl_lat_q <= PPL_RESET;
			lines_lat_q <= LINES_RESET;
			mode_q <= MODE_NONE;
		end else if (acc) begin
			if (wr_t0) timing_q[0] <= write_data;
			if (wr_t1) timing_q[1] <= write_data;
			if (wr_t2) timing_q[2] <= write_data;
			if (wr_t3) timing_q[3] <= write_data;
			upbase_q <= upbase_n;
			lpbase_q <= lpbase_n;
			control_q <= control_n;
			mask_q <= mask_n;
			raw_q <= raw_n;
			en_q <= en_n;
			ppl_pend_q <= ppl_pend_n;
			lines_pend_q <= lines_pend_n;
			ppl_lat_q <= ppl_lat_n;
			lines_lat_q <= lines_lat_n;
			mode_q <= mode_n;
		end
	end
endmodule

[rtl/core/lcd_controller_register_file.sv]
// Register file of a colour LCD controller. Each slave transfer is one bus access and
// produces exactly one master transfer, passing first through the stage with the registered
// palette read and then through the output register. A new access is taken every
// cycle while the result side accepts every cycle. When the result side stalls, two accesses
// are held (one in the output register, one waiting behind it) before s_axis_tready drops.
module lcd_controller_register_file #(
	parameter int PALETTE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] offset, [47:16] write_data, [52:48] irq_events, [55:53] zero
	input  logic [55:0] s_axis_tdata,
	// [0] kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] read_data, [33:32] access_fault, [34] irq_line, [35] screen_on,
	// [46:36] pixels_per_line, [57:47] lines_per_panel, [59:58] pixel_mode,
	// [91:60] frame_base, [95:92] zero
	output logic [95:0] m_axis_tdata
);
	import lcdc_pkg::*;

	logic              acc, adv, s1_valid_q, out_valid_q;
	acc_res_t          res, res_s1;
	pal_cmd_t          pal_cmd;
	logic [WORD_W-1:0] pal_rdata, rd_s1;
	logic [95:0]       out_data_q;

	assign adv = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || adv;
	assign acc = s_axis_tvalid && s_axis_tready;

	lcdc_regs #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.kind      (s_axis_tuser),
		.offset    (s_axis_tdata[15:0]),
		.write_data(s_axis_tdata[47:16]),
		.irq_events(s_axis_tdata[52:48]),
		.res       (res),
		.pal_cmd   (pal_cmd)
	);

	lcdc_pal #(
		.DEPTH(PALETTE_DEPTH)
	) u_pal (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (pal_cmd),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	// The palette word is read from a registered RAM at the access and arrives alongside the held result.
	assign rd_s1 = res_s1.pal_rd ? pal_rdata : res_s1.rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {4'b0000, res_s1.frame_base, res_s1.mode, res_s1.lines, res_s1.ppl,
				res_s1.screen_on, res_s1.irq, res_s1.fault, rd_s1};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
endmodule

[rtl/core/lcdc_checker.sv]
// Port-level checks on the result stream of the LCD controller register file.
// Bound to the top level; uses only its ports.
module lcdc_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:32] != 2'b11)
		else $error("fault code out of range");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33:32] != 2'b00 |-> m_axis_tdata[31:0] == 32'd0)
		else $error("faulting access returned data");

	a_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0 && m_axis_tdata[57:47] != 11'd0
			&& m_axis_tdata[59:58] != 2'b11)
		else $error("latched screen geometry malformed");
endmodule

bind lcd_controller_register_file lcdc_port_checks u_lcdc_port_checks (.*);
